// ----- hw/rtl/mbp_pkg.sv -----
// Package: shared types and constants for the MSB-first bit packer.
package mbp_pkg;

  localparam int unsigned CODE_W     = 64;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = CODE_W + BYTE_W;
  localparam int unsigned TOT_W      = 7;
  localparam logic [COUNT_W-1:0] MAX_CODE_BITS = 7'd64;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_RAW    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_EMIT,
    ST_FLUSH,
    ST_RAW
  } state_t;

  typedef enum logic [1:0] {
    SRC_WORD,
    SRC_PEND,
    SRC_RAW
  } src_t;

  typedef struct packed {
    logic load;
    logic align;
    logic emit;
    src_t emit_src;
    logic emit_last;
    logic store_rest;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic tot_ge8;
    logic tot_lt16;
    logic pend_nz;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/mbp_ifs.sv -----
// Interfaces: input item channel and output byte channel.
interface mbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] code;
  logic [6:0]  bit_count;
  logic [7:0]  raw_byte;

  modport source (output valid, output cmd, output code, output bit_count,
                  output raw_byte, input ready);
  modport sink (input valid, input cmd, input code, input bit_count,
                input raw_byte, output ready);
endinterface

interface mbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ----- hw/rtl/mbp_dpath.sv -----
// Datapath: pending byte, alignment word, bit counter and output register.
module mbp_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbp_pkg::ctrl_cmd_t   ctrl,
  input  logic [1:0]           in_cmd,
  input  logic [63:0]          in_code,
  input  logic [6:0]           in_bit_count,
  input  logic [7:0]           in_raw_byte,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output mbp_pkg::dp_status_t  status
);
  import mbp_pkg::*;

  logic [BYTE_W-1:0]  pend_byte_r, pend_byte_nxt;
  logic [2:0]         pend_bits_r, pend_bits_nxt;
  cmd_t               cmd_r;
  logic [BYTE_W-1:0]  raw_r;
  logic [CODE_W-1:0]  code_sh_r;
  logic [TOT_W-1:0]   tot_r, tot_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;
  logic [COUNT_W-1:0] nsat;
  logic [COUNT_W-1:0] sh_amt;
  logic [3:0]         pos_amt;

  assign nsat    = (in_bit_count > MAX_CODE_BITS) ? MAX_CODE_BITS : in_bit_count;
  assign sh_amt  = MAX_CODE_BITS - nsat;
  assign pos_amt = 4'd8 - {1'b0, pend_bits_r};

  always_comb begin
    pend_byte_nxt = pend_byte_r;
    pend_bits_nxt = pend_bits_r;
    tot_nxt       = tot_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (ctrl.load) begin
      tot_nxt = TOT_W'({4'b0, pend_bits_r}) + TOT_W'(nsat);
    end
    if (ctrl.align) begin
      word_nxt = {pend_byte_r, {CODE_W{1'b0}}} | ({{BYTE_W{1'b0}}, code_sh_r} << pos_amt);
    end
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = ctrl.emit_last;
      case (ctrl.emit_src)
        SRC_WORD: begin
          out_byte_nxt = word_r[WORD_W-1 -: BYTE_W];
          word_nxt     = word_r << BYTE_W;
          tot_nxt      = tot_r - TOT_W'(BYTE_W);
        end
        SRC_PEND: begin
          out_byte_nxt  = pend_byte_r;
          pend_byte_nxt = '0;
          pend_bits_nxt = '0;
        end
        SRC_RAW: out_byte_nxt = raw_r;
        default: out_byte_nxt = out_byte_r;
      endcase
    end
    if (ctrl.store_rest) begin
      pend_byte_nxt = word_r[WORD_W-1 -: BYTE_W];
      pend_bits_nxt = tot_r[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_byte_r <= '0;
      pend_bits_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_byte_r <= pend_byte_nxt;
      pend_bits_r <= pend_bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r     <= cmd_t'(in_cmd);
      raw_r     <= in_raw_byte;
      code_sh_r <= in_code << sh_amt;
    end
    tot_r      <= tot_nxt;
    word_r     <= word_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  assign status.cmd      = cmd_r;
  assign status.tot_ge8  = (tot_r >= TOT_W'(8));
  assign status.tot_lt16 = (tot_r < TOT_W'(16));
  assign status.pend_nz  = (pend_bits_r != 3'd0);
  assign status.out_free = ~out_valid_r | out_ready;

endmodule

// ----- hw/rtl/mbp_ctrl.sv -----
// Controller: sequences load, align, byte emission and flushes.
module mbp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_cmd,
  input  mbp_pkg::dp_status_t  status,
  output logic                 in_ready,
  output mbp_pkg::ctrl_cmd_t   ctrl
);
  import mbp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    ctrl.load       = 1'b0;
    ctrl.align      = 1'b0;
    ctrl.emit       = 1'b0;
    ctrl.emit_src   = SRC_WORD;
    ctrl.emit_last  = 1'b0;
    ctrl.store_rest = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          case (cmd_t'(in_cmd))
            CMD_APPEND: state_nxt = ST_ALIGN;
            CMD_FLUSH:  state_nxt = ST_FLUSH;
            CMD_RAW:    state_nxt = ST_FLUSH;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ALIGN: begin
        ctrl.align = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.tot_ge8) begin
          if (status.out_free) begin
            ctrl.emit      = 1'b1;
            ctrl.emit_src  = SRC_WORD;
            ctrl.emit_last = status.tot_lt16;
          end
        end else begin
          ctrl.store_rest = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_nz) begin
          state_nxt = (status.cmd == CMD_RAW) ? ST_RAW : ST_IDLE;
        end else if (status.out_free) begin
          ctrl.emit      = 1'b1;
          ctrl.emit_src  = SRC_PEND;
          ctrl.emit_last = (status.cmd == CMD_FLUSH);
          state_nxt      = (status.cmd == CMD_RAW) ? ST_RAW : ST_IDLE;
        end
      end
      ST_RAW: begin
        if (status.out_free) begin
          ctrl.emit      = 1'b1;
          ctrl.emit_src  = SRC_RAW;
          ctrl.emit_last = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/msb_first_bit_packer_top.sv -----
// Top level: MSB-first variable-length bit packer.
//
//   channel   dir  payload                          beat
//   in_ch     in   cmd, code, bit_count, raw_byte   one command
//   out_ch    out  out_byte, last                   one byte
//
// Append: accept, align, then one completed byte per cycle (up to 8)
// while the output is free, then store the leftover. Flush/raw: partial
// byte, then raw byte. Bytes leave through a single output register.
// Output stalls hold the sequencer in place; nothing is dropped. Reset
// (synchronous, active-low) clears the pending bits and the output valid.
module msb_first_bit_packer_top (
  input  logic       clk,
  input  logic       rst_n,
  mbp_in_if.sink     in_ch,
  mbp_out_if.source  out_ch
);
  import mbp_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  mbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .status   (status),
    .in_ready (in_ch.ready),
    .ctrl     (ctrl)
  );

  mbp_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .in_cmd       (in_ch.cmd),
    .in_code      (in_ch.code),
    .in_bit_count (in_ch.bit_count),
    .in_raw_byte  (in_ch.raw_byte),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_byte     (out_ch.out_byte),
    .out_last     (out_ch.last),
    .status       (status)
  );

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the MSB-first bit packer: directed and random command beats checked against a packing predictor.
`timescale 1ns / 1ps

module tb_top;
  import mbp_pkg::*;

  typedef struct {
    cmd_t        cmd;
    logic [63:0] code;
    logic [6:0]  bit_count;
    logic [7:0]  raw_byte;
  } pack_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  mbp_in_if  in_if ();
  mbp_out_if out_if ();

  msb_first_bit_packer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  logic      drv_valid = 1'b0;
  pack_cmd_t drv_cmd = '{CMD_NONE, 64'd0, 7'd0, 8'd0};
  logic      rcv_ready = 1'b0;

  assign in_if.valid     = drv_valid;
  assign in_if.cmd       = drv_cmd.cmd;
  assign in_if.code      = drv_cmd.code;
  assign in_if.bit_count = drv_cmd.bit_count;
  assign in_if.raw_byte  = drv_cmd.raw_byte;
  assign out_if.ready    = rcv_ready;

  pack_cmd_t    cmd_q[$];
  packed_byte_t exp_bytes_q[$];
  int           err_cnt = 0;

  // packer state
  logic [7:0] acc_byte = 8'd0;
  int         acc_bits = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic add_cmd(input cmd_t cmd, input logic [63:0] code,
                         input logic [6:0] bit_count, input logic [7:0] raw_byte);
    pack_cmd_t c;
    c.cmd       = cmd;
    c.code      = code;
    c.bit_count = bit_count;
    c.raw_byte  = raw_byte;
    cmd_q.push_back(c);
  endtask

  task automatic pack_into_bytes(input pack_cmd_t c);
    logic [7:0]   done[$];
    packed_byte_t e;
    int           nbits;
    int           i;
    case (c.cmd)
      CMD_APPEND: begin
        nbits = (c.bit_count > MAX_CODE_BITS) ? int'(MAX_CODE_BITS) : int'(c.bit_count);
        for (i = nbits - 1; i >= 0; i--) begin
          if (c.code[i]) begin
            acc_byte = acc_byte | (8'h80 >> acc_bits);
          end
          acc_bits++;
          if (acc_bits == 8) begin
            done.push_back(acc_byte);
            acc_byte = 8'd0;
            acc_bits = 0;
          end
        end
      end
      CMD_FLUSH, CMD_RAW: begin
        if (acc_bits != 0) begin
          done.push_back(acc_byte);
          acc_byte = 8'd0;
          acc_bits = 0;
        end
        if (c.cmd == CMD_RAW) begin
          done.push_back(c.raw_byte);
        end
      end
      default: ;
    endcase
    for (i = 0; i < done.size(); i++) begin
      e.data = done[i];
      e.last = (i == done.size() - 1);
      exp_bytes_q.push_back(e);
    end
  endtask

  // driver: bursts with random gaps
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        pack_into_bytes(drv_cmd);
        void'(cmd_q.pop_front());
      end
      if (!drv_valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          drv_cmd   <= cmd_q[0];
          drv_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, reloaded when the pattern position wraps
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_pos = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= stall_pat[pat_pos];
      pat_pos++;
      if (pat_pos == 16) begin
        pat_pos   = 0;
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end
    end
  end

  // monitor
  packed_byte_t got_exp;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (exp_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%02h last=%0b",
                                  out_if.out_byte, out_if.last));
      end else begin
        got_exp = exp_bytes_q.pop_front();
        if (out_if.out_byte !== got_exp.data) begin
          report_mismatch($sformatf("out_byte got %02h exp %02h",
                                    out_if.out_byte, got_exp.data));
        end
        if (out_if.last !== got_exp.last) begin
          report_mismatch($sformatf("last got %0b exp %0b (byte %02h)",
                                    out_if.last, got_exp.last, got_exp.data));
        end
      end
    end
  end

  initial begin
    int          r;
    int          i;
    cmd_t        c;
    logic [6:0]  cnt;

    add_cmd(CMD_APPEND, {64{1'b1}}, 7'd64, 8'h00);
    add_cmd(CMD_APPEND, 64'd0, 7'd64, 8'hFF);
    add_cmd(CMD_APPEND, 64'h1, 7'd1, 8'h00);
    add_cmd(CMD_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 8'hFF);
    add_cmd(CMD_FLUSH, 64'd0, 7'd0, 8'h00);
    add_cmd(CMD_APPEND, 64'h5, 7'd3, 8'h00);
    add_cmd(CMD_RAW, 64'd0, 7'd0, 8'hA5);
    add_cmd(CMD_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 8'h00);
    add_cmd(CMD_RAW, 64'd0, 7'd0, 8'hFF);
    add_cmd(CMD_APPEND, 64'hDEAD_BEEF_0123_4567, 7'd0, 8'h00);
    add_cmd(CMD_APPEND, 64'h8000_0000_0000_0001, 7'd127, 8'h00);
    add_cmd(CMD_APPEND, 64'h0123_4567_89AB_CDEF, 7'd65, 8'h00);
    add_cmd(CMD_APPEND, 64'h7F, 7'd7, 8'h00);
    add_cmd(CMD_APPEND, 64'h0, 7'd1, 8'h00);
    add_cmd(CMD_APPEND, 64'h15, 7'd5, 8'h00);
    add_cmd(CMD_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 8'h00);
    add_cmd(CMD_FLUSH, 64'd0, 7'd0, 8'h00);
    add_cmd(CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 8'hFF);
    add_cmd(CMD_APPEND, 64'h3, 7'd2, 8'h00);
    add_cmd(CMD_NONE, 64'h0, 7'd0, 8'h00);
    add_cmd(CMD_APPEND, 64'h5555_5555_5555_5555, 7'd63, 8'h00);
    add_cmd(CMD_RAW, 64'd0, 7'd0, 8'h5A);

    for (i = 0; i < 250; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        c   = CMD_APPEND;
        cnt = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 12))
                                         : 7'($urandom_range(13, 64));
      end else if (r < 66) begin
        c   = CMD_APPEND;
        cnt = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
      end else if (r < 80) begin
        c   = CMD_FLUSH;
        cnt = 7'($urandom);
      end else if (r < 95) begin
        c   = CMD_RAW;
        cnt = 7'($urandom);
      end else begin
        c   = CMD_NONE;
        cnt = 7'($urandom);
      end
      add_cmd(c, {32'($urandom), 32'($urandom)}, cnt, 8'($urandom));
    end
    add_cmd(CMD_FLUSH, 64'd0, 7'd0, 8'h00);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || drv_valid) @(posedge clk);
    while (exp_bytes_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (exp_bytes_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never arrived", exp_bytes_q.size()));
    end
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
